FILE: hdl/s3c_pkg.sv
package s3c_pkg;

  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;
  localparam int PIXEL_BITS = 16;
  localparam int FRAC_BITS  = 12;
  localparam int GAIN_W     = 16;
  localparam int SIZE_W     = 13;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);

  // widths of the tap sums, products, pair sums, final sum and rounded result
  localparam int SUM2_W = PIXEL_BITS + 1;
  localparam int SUM4_W = PIXEL_BITS + 2;
  localparam int PC_W   = GAIN_W + PIXEL_BITS;
  localparam int P2_W   = GAIN_W + SUM2_W;
  localparam int P4_W   = GAIN_W + SUM4_W;
  localparam int PS_W   = P4_W + 1;
  localparam int ACC_W  = P4_W + 2;
  localparam int RND_W  = ACC_W - FRAC_BITS;

  // result queue
  localparam int Q_DEPTH = 8;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int QC_W    = $clog2(Q_DEPTH + 1);

  // apb
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;

  typedef logic signed [PIXEL_BITS-1:0] pixel_t;
  typedef logic signed [GAIN_W-1:0]     gain_t;

  typedef enum logic [2:0] {
    REG_WIDTH    = 3'd0,
    REG_HEIGHT   = 3'd1,
    REG_CENTER   = 3'd2,
    REG_SIDE     = 3'd3,
    REG_VERTICAL = 3'd4,
    REG_CORNER   = 3'd5
  } reg_idx_t;

  // per-pixel tag that travels down the pipe
  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    pixel_t           pix;
    logic             filt;
    logic             pass;
  } pix_tag_t;

  typedef struct packed {
    pix_tag_t tag;
    pixel_t   filt_val;
  } q_entry_t;

endpackage

FILE: hdl/symmetric_3x3_convolver.sv
// Symmetric 3x3 convolver over one raster-order image plane of signed Q3.12 pixels. The block
// takes one pixel per clock through the pixel_in channel: two 4096 x 16 line memories (read at
// the edge that takes the pixel, written back at the next edge) hold the two rows above, and six
// window registers hold the two columns to the left. Each pixel completes the window centered one
// row up and one column left; for an interior center the block emits
// center*C + side*(L+R) + vertical*(U+D) + corner*(corners), rounded to Q3.12 (ties up) and
// saturated, while border pixels come out unchanged as they arrive. A pixel that does both gives
// two beats, the filtered one first; run_end marks the last beat of a pixel. A pixel is taken
// every clock as long as the eight-entry result queue plus the four pipeline stages have room,
// so the sustained rate is one pixel per clock, or one output beat per clock when the output side
// or two-beat pixels set the pace. Line memories are not cleared after reset: their contents
// count only once written by the current plane.
// Registers sit on the apb port at byte addresses 0 (width), 4 (height), 8 (center gain),
// 12 (side gain), 16 (vertical gain) and 20 (corner gain); write them only while the block idles.
module symmetric_3x3_convolver (
  input  logic                           clk,
  input  logic                           rst,
  // apb configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [s3c_pkg::PADDR_W-1:0]    paddr,
  input  logic [s3c_pkg::PDATA_W-1:0]    pwdata,
  output logic [s3c_pkg::PDATA_W-1:0]    prdata,
  output logic                           pready,
  // pixel input channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  s3c_pkg::pixel_t                pixel_in,
  // result channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [s3c_pkg::COL_W-1:0]      out_col,
  output logic [s3c_pkg::ROW_W-1:0]      out_row,
  output s3c_pkg::pixel_t                out_value,
  output logic                           run_end
);

  import s3c_pkg::*;

  // ---------------------------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------------------------
  logic [SIZE_W-1:0] img_w;
  logic [SIZE_W-1:0] img_h;
  gain_t             gain_c;
  gain_t             gain_s;
  gain_t             gain_v;
  gain_t             gain_d;
  reg_idx_t          reg_idx;

  assign reg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      img_w  <= SIZE_W'(640);
      img_h  <= SIZE_W'(480);
      gain_c <= GAIN_W'(4096);
      gain_s <= '0;
      gain_v <= '0;
      gain_d <= '0;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx)
        REG_WIDTH:    img_w  <= pwdata[SIZE_W-1:0];
        REG_HEIGHT:   img_h  <= pwdata[SIZE_W-1:0];
        REG_CENTER:   gain_c <= pwdata[GAIN_W-1:0];
        REG_SIDE:     gain_s <= pwdata[GAIN_W-1:0];
        REG_VERTICAL: gain_v <= pwdata[GAIN_W-1:0];
        REG_CORNER:   gain_d <= pwdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // readback, zero extended
  always_comb begin
    prdata = '0;
    case (reg_idx)
      REG_WIDTH:    prdata[SIZE_W-1:0] = img_w;
      REG_HEIGHT:   prdata[SIZE_W-1:0] = img_h;
      REG_CENTER:   prdata[GAIN_W-1:0] = gain_c;
      REG_SIDE:     prdata[GAIN_W-1:0] = gain_s;
      REG_VERTICAL: prdata[GAIN_W-1:0] = gain_v;
      REG_CORNER:   prdata[GAIN_W-1:0] = gain_d;
      default:      prdata = '0;
    endcase
  end

  // sizes in use: width clamped to 1..MAX_WIDTH, height to 1..MAX_HEIGHT
  logic [SIZE_W-1:0] w_eff;
  logic [SIZE_W-1:0] h_eff;

  always_comb begin
    if (img_w == '0) begin
      w_eff = SIZE_W'(1);
    end else if (img_w > SIZE_W'(MAX_WIDTH)) begin
      w_eff = SIZE_W'(MAX_WIDTH);
    end else begin
      w_eff = img_w;
    end
    if (img_h == '0) begin
      h_eff = SIZE_W'(1);
    end else if (img_h > SIZE_W'(MAX_HEIGHT)) begin
      h_eff = SIZE_W'(MAX_HEIGHT);
    end else begin
      h_eff = img_h;
    end
  end

  // ---------------------------------------------------------------------------------------------
  // raster position and intake
  // ---------------------------------------------------------------------------------------------
  logic [COL_W-1:0]  col_count;
  logic [ROW_W-1:0]  row_count;
  logic [COL_W-1:0]  col_cur;
  logic [ROW_W-1:0]  row_cur;
  logic [COL_W-1:0]  col_count_next;
  logic [ROW_W-1:0]  row_count_next;
  logic [SIZE_W-1:0] col_inc;
  logic [SIZE_W-1:0] row_inc;
  logic              accept;
  pix_tag_t          tag0;

  assign accept = in_valid && in_ready;

  // a counter at or past the size in use (size shrank mid-plane) restarts at zero
  assign col_cur = (SIZE_W'(col_count) >= w_eff) ? '0 : col_count;
  assign row_cur = (SIZE_W'(row_count) >= h_eff) ? '0 : row_count;
  assign col_inc = SIZE_W'(col_cur) + SIZE_W'(1);
  assign row_inc = SIZE_W'(row_cur) + SIZE_W'(1);

  always_comb begin
    col_count_next = col_inc[COL_W-1:0];
    row_count_next = row_cur;
    if (col_inc >= w_eff) begin
      col_count_next = '0;
      row_count_next = (row_inc >= h_eff) ? '0 : row_inc[ROW_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (accept) begin
      col_count <= col_count_next;
      row_count <= row_count_next;
    end
  end

  // interior window completes at col,row >= 2; border test is on the arriving pixel
  always_comb begin
    tag0.col  = col_cur;
    tag0.row  = row_cur;
    tag0.pix  = pixel_in;
    tag0.filt = (col_cur >= COL_W'(2)) && (row_cur >= ROW_W'(2));
    tag0.pass = (col_cur == '0) || (row_cur == '0) ||
                (SIZE_W'(col_cur) == w_eff - SIZE_W'(1)) ||
                (SIZE_W'(row_cur) == h_eff - SIZE_W'(1));
  end

  // ---------------------------------------------------------------------------------------------
  // line memories: read at intake, written back by the stage 1 beat in the next cycle, not later
  // ---------------------------------------------------------------------------------------------
  pixel_t   older_mem [MAX_WIDTH];
  pixel_t   newer_mem [MAX_WIDTH];
  pixel_t   top_rd;
  pixel_t   mid_rd;

  logic     v1;
  pix_tag_t t1;
  logic     fwd1;
  pixel_t   fwd_top1;
  pixel_t   fwd_mid1;
  pixel_t   top_eff;
  pixel_t   mid_eff;

  // the beat in stage 1 writes the same column that a pixel taken now reads (width of one)
  assign top_eff = fwd1 ? fwd_top1 : top_rd;
  assign mid_eff = fwd1 ? fwd_mid1 : mid_rd;

  always_ff @(posedge clk) begin
    if (accept) begin
      top_rd <= older_mem[col_cur];
    end
    if (v1) begin
      older_mem[t1.col] <= mid_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mid_rd <= newer_mem[col_cur];
    end
    if (v1) begin
      newer_mem[t1.col] <= t1.pix;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      t1       <= tag0;
      fwd1     <= v1 && (t1.col == col_cur);
      fwd_top1 <= mid_eff;
      fwd_mid1 <= t1.pix;
    end
  end

  // ---------------------------------------------------------------------------------------------
  // window registers and tap sums (stage 1)
  // win: 0 top col-1, 1 top col-2, 2 mid col-1, 3 mid col-2, 4 new col-1, 5 new col-2
  // ---------------------------------------------------------------------------------------------
  pixel_t                     win [6];
  logic signed [SUM2_W-1:0]   sum_lr;
  logic signed [SUM2_W-1:0]   sum_ud;
  logic signed [SUM4_W-1:0]   sum_cr;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) begin
        win[i] <= '0;
      end
    end else if (v1) begin
      win[1] <= win[0];
      win[0] <= top_eff;
      win[3] <= win[2];
      win[2] <= mid_eff;
      win[5] <= win[4];
      win[4] <= t1.pix;
    end
  end

  assign sum_lr = SUM2_W'(win[3]) + SUM2_W'(mid_eff);
  assign sum_ud = SUM2_W'(win[0]) + SUM2_W'(win[4]);
  assign sum_cr = SUM4_W'(win[1]) + SUM4_W'(top_eff) + SUM4_W'(win[5]) + SUM4_W'(t1.pix);

  // stage 2: tap sums
  logic                     v2;
  pix_tag_t                 t2;
  pixel_t                   s2_c;
  logic signed [SUM2_W-1:0] s2_lr;
  logic signed [SUM2_W-1:0] s2_ud;
  logic signed [SUM4_W-1:0] s2_cr;

  always_ff @(posedge clk) begin
    t2    <= t1;
    s2_c  <= win[2];
    s2_lr <= sum_lr;
    s2_ud <= sum_ud;
    s2_cr <= sum_cr;
  end

  // stage 3: products
  logic                   v3;
  pix_tag_t               t3;
  logic signed [PC_W-1:0] p_c;
  logic signed [P2_W-1:0] p_lr;
  logic signed [P2_W-1:0] p_ud;
  logic signed [P4_W-1:0] p_cr;

  always_ff @(posedge clk) begin
    t3   <= t2;
    p_c  <= gain_c * s2_c;
    p_lr <= gain_s * s2_lr;
    p_ud <= gain_v * s2_ud;
    p_cr <= gain_d * s2_cr;
  end

  // stage 4: pair sums
  logic                   v4;
  pix_tag_t               t4;
  logic signed [PS_W-1:0] ps_a;
  logic signed [PS_W-1:0] ps_b;

  always_ff @(posedge clk) begin
    t4   <= t3;
    ps_a <= PS_W'(p_c) + PS_W'(p_lr);
    ps_b <= PS_W'(p_ud) + PS_W'(p_cr);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  // final sum, round half up, saturate
  logic signed [ACC_W-1:0] acc;
  logic signed [RND_W-1:0] rnd;
  logic                    rnd_fits;
  pixel_t                  filt_val;

  assign acc      = ACC_W'(ps_a) + ACC_W'(ps_b) + ACC_W'(1 << (FRAC_BITS - 1));
  assign rnd      = acc[ACC_W-1:FRAC_BITS];
  assign rnd_fits = (&rnd[RND_W-1:PIXEL_BITS-1]) || !(|rnd[RND_W-1:PIXEL_BITS-1]);

  always_comb begin
    if (rnd_fits) begin
      filt_val = rnd[PIXEL_BITS-1:0];
    end else if (rnd[RND_W-1]) begin
      filt_val = {1'b1, {(PIXEL_BITS-1){1'b0}}};
    end else begin
      filt_val = {1'b0, {(PIXEL_BITS-1){1'b1}}};
    end
  end

  // ---------------------------------------------------------------------------------------------
  // result queue: one entry per pixel with one or two beats
  // ---------------------------------------------------------------------------------------------
  q_entry_t         q_mem [Q_DEPTH];
  logic [Q_AW-1:0]  q_head;
  logic [Q_AW-1:0]  q_tail;
  logic [QC_W-1:0]  q_count;
  logic             phase;
  logic             q_wr;
  logic             q_pop;
  logic             beat;
  logic             first_filt;
  q_entry_t         qh;
  logic [2:0]       inflight;
  logic [QC_W:0]    occupancy;

  assign q_wr = v4 && (t4.filt || t4.pass);

  always_ff @(posedge clk) begin
    if (q_wr) begin
      q_mem[q_tail] <= '{tag: t4, filt_val: filt_val};
    end
  end

  assign qh         = q_mem[q_head];
  assign out_valid  = (q_count != '0);
  assign first_filt = qh.tag.filt && !phase;
  assign out_col    = first_filt ? qh.tag.col - COL_W'(1) : qh.tag.col;
  assign out_row    = first_filt ? qh.tag.row - ROW_W'(1) : qh.tag.row;
  assign out_value  = first_filt ? qh.filt_val : qh.tag.pix;
  assign run_end    = !(first_filt && qh.tag.pass);
  assign beat       = out_valid && out_ready;
  assign q_pop      = beat && run_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_head  <= '0;
      q_tail  <= '0;
      q_count <= '0;
      phase   <= 1'b0;
    end else begin
      if (q_wr) begin
        q_tail <= q_tail + Q_AW'(1);
      end
      if (q_pop) begin
        q_head <= q_head + Q_AW'(1);
      end
      if (q_wr && !q_pop) begin
        q_count <= q_count + QC_W'(1);
      end else if (!q_wr && q_pop) begin
        q_count <= q_count - QC_W'(1);
      end
      if (beat) begin
        phase <= !run_end;
      end
    end
  end

  // each pixel in the pipe holds a queue slot in reserve
  assign inflight  = 3'(v1) + 3'(v2) + 3'(v3) + 3'(v4);
  assign occupancy = (QC_W + 1)'(q_count) + (QC_W + 1)'(inflight);
  assign in_ready  = (occupancy < (QC_W + 1)'(Q_DEPTH));

`ifndef SYNTHESIS
  a_no_overbook: assert property (@(posedge clk) disable iff (rst)
    occupancy <= (QC_W + 1)'(Q_DEPTH))
    else $error("result queue overbooked");

  a_no_write_full: assert property (@(posedge clk) disable iff (rst)
    q_wr |-> (q_count < QC_W'(Q_DEPTH)))
    else $error("result queue written while full");

  a_pair_completes: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !run_end) |=> (out_valid && run_end))
    else $error("second beat of a pixel missing");

  a_fwd_same_col: assert property (@(posedge clk) disable iff (rst)
    (accept && v1 && (t1.col == col_cur)) |=> fwd1)
    else $error("line memory forwarding missed");
`endif

endmodule

FILE: verif/tb_symmetric_3x3_convolver.sv
`timescale 1ns / 100ps

module tb_symmetric_3x3_convolver;
  import s3c_pkg::*;

  // idle chance per cycle on either side, in percent
  localparam int IDLE_PCT = 7;
  // cycles to let the pipe settle once nothing more is expected
  localparam int SETTLE_CYCLES = 20;
  // random stimulus size, in pixels
  localparam int RANDOM_PIXELS = 600;
  // pixels sent into a plane of clamped size before moving on
  localparam int EXTREME_PIXELS = 40;
  // register index that decodes to nothing
  localparam int SPARE_REG = 6;
  // rounding constant and saturation bounds of a Q3.12 result
  localparam longint HALF_LSB = longint'(1) <<< (FRAC_BITS - 1);
  localparam longint PIX_MAX = (longint'(1) <<< (PIXEL_BITS - 1)) - 1;
  localparam longint PIX_MIN = -(longint'(1) <<< (PIXEL_BITS - 1));

  // one beat of the result channel
  typedef struct {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    pixel_t           value;
    logic             last;
  } beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  logic   in_valid = 1'b0;
  logic   in_ready;
  pixel_t pixel_in = '0;

  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [COL_W-1:0] out_col;
  logic [ROW_W-1:0] out_row;
  pixel_t           out_value;
  logic             run_end;

  // beats still owed by the block, oldest first
  beat_t pending_beats[$];
  int    errors = 0;
  // no idling on either side while set
  bit    calm = 1'b0;

  // register shadow, reset values
  logic [SIZE_W-1:0] width_cfg = 13'd640;
  logic [SIZE_W-1:0] height_cfg = 13'd480;
  gain_t             center_cfg = 16'sd4096;
  gain_t             side_cfg = '0;
  gain_t             vert_cfg = '0;
  gain_t             corner_cfg = '0;

  // own copy of the line memories, window and raster position
  pixel_t      older_mem [MAX_WIDTH];
  pixel_t      newer_mem [MAX_WIDTH];
  pixel_t      top_ctr = '0, top_left = '0;
  pixel_t      mid_ctr = '0, mid_left = '0;
  pixel_t      bot_ctr = '0, bot_left = '0;
  int unsigned col_pos = 0;
  int unsigned row_pos = 0;

  symmetric_3x3_convolver i_dut (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .pixel_in  (pixel_in),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_col   (out_col),
    .out_row   (out_row),
    .out_value (out_value),
    .run_end   (run_end)
  );

  always #5 clk = ~clk;

  // receiver stalls at random except in the calm stretch
  always @(negedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  // raster model: one pixel in, zero to two beats owed
  task automatic convolve_pixel(input pixel_t px);
    int unsigned w, h, c, r;
    pixel_t      up_px, mid_px;
    longint      acc, rounded;
    bit          filt, pass;
    beat_t       b;
    // sizes are clamped to what the line memories hold
    w = width_cfg;
    h = height_cfg;
    if (w < 1) w = 1;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    if (h < 1) h = 1;
    if (h > MAX_HEIGHT) h = MAX_HEIGHT;
    // a shrunk size restarts the counter that overran it
    if (col_pos >= w) col_pos = 0;
    if (row_pos >= h) row_pos = 0;
    c = col_pos;
    r = row_pos;
    up_px = older_mem[c];
    mid_px = newer_mem[c];
    filt = (c >= 2) && (r >= 2);
    pass = (c == 0) || (r == 0) || (c == w - 1) || (r == h - 1);
    // window centered one row up and one column left, original pixels only
    if (filt) begin
      acc = longint'(center_cfg) * longint'(mid_ctr)
          + longint'(side_cfg) * (longint'(mid_left) + longint'(mid_px))
          + longint'(vert_cfg) * (longint'(top_ctr) + longint'(bot_ctr))
          + longint'(corner_cfg) * (longint'(top_left) + longint'(up_px)
                                    + longint'(bot_left) + longint'(px));
      // round half up, then clip to the pixel range
      rounded = (acc + HALF_LSB) >>> FRAC_BITS;
      if (rounded > PIX_MAX) rounded = PIX_MAX;
      if (rounded < PIX_MIN) rounded = PIX_MIN;
      b.col = COL_W'(c - 1);
      b.row = ROW_W'(r - 1);
      b.value = pixel_t'(rounded);
      b.last = !pass;
      pending_beats.push_back(b);
    end
    // border pixel goes straight through, after any filtered beat
    if (pass) begin
      b.col = COL_W'(c);
      b.row = ROW_W'(r);
      b.value = px;
      b.last = 1'b1;
      pending_beats.push_back(b);
    end
    top_left = top_ctr;
    top_ctr = up_px;
    mid_left = mid_ctr;
    mid_ctr = mid_px;
    bot_left = bot_ctr;
    bot_ctr = px;
    older_mem[c] = mid_px;
    newer_mem[c] = px;
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    col_pos = c;
    row_pos = r;
  endtask

  // apb write: setup cycle, then access cycle until pready
  task automatic write_reg(input int unsigned idx, input logic [PDATA_W-1:0] data);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = PADDR_W'(idx << 2);
    pwdata = data;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_WIDTH:    width_cfg = data[SIZE_W-1:0];
      REG_HEIGHT:   height_cfg = data[SIZE_W-1:0];
      REG_CENTER:   center_cfg = data[GAIN_W-1:0];
      REG_SIDE:     side_cfg = data[GAIN_W-1:0];
      REG_VERTICAL: vert_cfg = data[GAIN_W-1:0];
      REG_CORNER:   corner_cfg = data[GAIN_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  // random junk above the field, field bits kept
  function automatic logic [PDATA_W-1:0] junk_above(input logic [PDATA_W-1:0] v,
                                                    input int bits);
    logic [PDATA_W-1:0] mask;
    mask = (32'd1 << bits) - 1;
    return ($urandom & ~mask) | (v & mask);
  endfunction

  function automatic pixel_t rand_pixel();
    case ($urandom_range(7))
      0: return pixel_t'(PIX_MAX);
      1: return pixel_t'(PIX_MIN);
      default: return pixel_t'($urandom);
    endcase
  endfunction

  function automatic gain_t pick_gain();
    case ($urandom_range(7))
      0: return gain_t'(PIX_MAX);
      1: return gain_t'(PIX_MIN);
      2: return '0;
      3: return 16'sd4096;
      default: return gain_t'($urandom);
    endcase
  endfunction

  // wait for every owed beat, optionally let the pipe settle too
  task automatic drain(input bit settle);
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    if (settle) repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // one pixel beat, with random gaps in front of it
  // valid stays up past the accepting edge; the next falling edge drops it or brings a new pixel
  task automatic send_pixel(input pixel_t px);
    @(negedge clk);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    pixel_in = px;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    convolve_pixel(px);
  endtask

  // new frame setup, only once the block is idle
  task automatic set_frame(input int w, input int h, input gain_t cg, input gain_t sg,
                           input gain_t vg, input gain_t kg);
    drain(1'b1);
    write_reg(REG_WIDTH, junk_above(w, SIZE_W));
    write_reg(REG_HEIGHT, junk_above(h, SIZE_W));
    write_reg(REG_CENTER, junk_above(32'(cg), GAIN_W));
    write_reg(REG_SIDE, junk_above(32'(sg), GAIN_W));
    write_reg(REG_VERTICAL, junk_above(32'(vg), GAIN_W));
    write_reg(REG_CORNER, junk_above(32'(kg), GAIN_W));
  endtask

  // pixels until the raster wraps back to the origin
  // flat: ring value everywhere except the first window center
  task automatic send_plane(input bit flat, input pixel_t ring_px, input pixel_t ctr_px);
    do begin
      if (flat) send_pixel((col_pos == 1 && row_pos == 1) ? ctr_px : ring_px);
      else send_pixel(rand_pixel());
      // now and then hold off until the block has caught up
      if (!flat && $urandom_range(63) == 0) drain(1'b0);
    end while (col_pos != 0 || row_pos != 0);
  endtask

  // reset sizes and gains, then a shrink that restarts the column count
  task automatic test_reset_defaults();
    repeat (7) send_pixel(rand_pixel());
    drain(1'b1);
    write_reg(REG_WIDTH, 32'd5);
    write_reg(REG_HEIGHT, 32'd4);
    // nothing decodes here, shadow stays as is
    write_reg(SPARE_REG, $urandom);
    send_plane(1'b0, '0, '0);
  endtask

  // ties round up, sums clip at both ends, extreme gains
  task automatic test_round_and_clip();
    set_frame(3, 3, 16'sd2048, '0, '0, '0);
    send_plane(1'b1, 16'sd5, 16'sd1);
    send_plane(1'b1, 16'sd5, -16'sd1);
    set_frame(3, 3, gain_t'(PIX_MAX), gain_t'(PIX_MAX), gain_t'(PIX_MAX), gain_t'(PIX_MAX));
    send_plane(1'b1, pixel_t'(PIX_MAX), pixel_t'(PIX_MAX));
    send_plane(1'b1, pixel_t'(PIX_MIN), pixel_t'(PIX_MIN));
    set_frame(3, 3, gain_t'(PIX_MIN), gain_t'(PIX_MIN), gain_t'(PIX_MIN), gain_t'(PIX_MIN));
    send_plane(1'b1, pixel_t'(PIX_MIN), pixel_t'(PIX_MIN));
  endtask

  // distinct gains per tap so a swapped neighbor shows up
  task automatic test_kernel_taps();
    set_frame(4, 4, 16'sd4096, 16'sd1, 16'sd16, 16'sd256);
    send_plane(1'b0, '0, '0);
    set_frame(5, 4, pick_gain(), pick_gain(), pick_gain(), pick_gain());
    send_plane(1'b0, '0, '0);
  endtask

  // sizes shrunk in the middle of a plane
  task automatic test_mid_plane_resize();
    set_frame(6, 6, pick_gain(), pick_gain(), pick_gain(), pick_gain());
    repeat (22) send_pixel(rand_pixel());
    // column 4 is past the new width: column restarts, row stays
    drain(1'b1);
    write_reg(REG_WIDTH, 32'd3);
    repeat (4) send_pixel(rand_pixel());
    // row 4 is past the new height: row restarts
    drain(1'b1);
    write_reg(REG_HEIGHT, 32'd2);
    send_plane(1'b0, '0, '0);
  endtask

  // zero sizes clamp up; oversized sizes clamp down, tried on the start of a plane
  task automatic test_size_extremes();
    set_frame(0, 3, pick_gain(), pick_gain(), pick_gain(), pick_gain());
    send_plane(1'b0, '0, '0);
    set_frame(2, 0, pick_gain(), pick_gain(), pick_gain(), pick_gain());
    send_plane(1'b0, '0, '0);
    set_frame(8191, 3, pick_gain(), pick_gain(), pick_gain(), pick_gain());
    repeat (EXTREME_PIXELS) send_pixel(rand_pixel());
    // column count past the new width of one restarts
    set_frame(0, 8191, pick_gain(), pick_gain(), pick_gain(), pick_gain());
    repeat (EXTREME_PIXELS) send_pixel(rand_pixel());
  endtask

  // small random planes, random gains, a calm stretch in the middle
  task automatic test_random_planes();
    int sent_total;
    int w, h;
    sent_total = 0;
    while (sent_total < RANDOM_PIXELS) begin
      w = $urandom_range(1, 10);
      h = $urandom_range(1, 8);
      set_frame(w, h, pick_gain(), pick_gain(), pick_gain(), pick_gain());
      calm = (sent_total >= 200) && (sent_total < 450);
      send_plane(1'b0, '0, '0);
      sent_total += w * h;
    end
    calm = 1'b0;
  endtask

  // result checker: each beat against the oldest owed one
  always @(posedge clk) begin : check_beat
    beat_t exp_b;
    if (!rst && out_valid && out_ready) begin
      if (pending_beats.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat col %0d row %0d value %0d", $time,
                 out_col, out_row, out_value);
      end else begin
        exp_b = pending_beats.pop_front();
        if (out_col !== exp_b.col) begin
          errors++;
          $display("%0t: out_col expected %0d actual %0d", $time, exp_b.col, out_col);
        end
        if (out_row !== exp_b.row) begin
          errors++;
          $display("%0t: out_row expected %0d actual %0d", $time, exp_b.row, out_row);
        end
        if (out_value !== exp_b.value) begin
          errors++;
          $display("%0t: out_value expected %0d actual %0d", $time, exp_b.value, out_value);
        end
        if (run_end !== exp_b.last) begin
          errors++;
          $display("%0t: run_end expected %0b actual %0b", $time, exp_b.last, run_end);
        end
      end
    end
  end

  // sequence of tests
  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_reset_defaults();
    test_round_and_clip();
    test_kernel_taps();
    test_mid_plane_resize();
    test_size_extremes();
    test_random_planes();
    drain(1'b1);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // hang guard, far above the slowest correct run
  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

FILE: files.f
hdl/s3c_pkg.sv
hdl/symmetric_3x3_convolver.sv
verif/tb_symmetric_3x3_convolver.sv
